@@ sv/froe_pkg.sv @@
// shared types and constants for the four-register opcode executor
package froe_pkg;

	localparam int NUM_REGS = 4;
	localparam int IDX_W    = $clog2(NUM_REGS);
	localparam int WORD_W   = 32;
	localparam int IMM_W    = 31;
	localparam int OP_W     = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [IMM_W-1:0]  imm_t;

	typedef enum logic [OP_W-1:0] {
		OP_GTIR = 4'd0,
		OP_MULR = 4'd1,
		OP_SETI = 4'd2,
		OP_GTRR = 4'd3,
		OP_BORI = 4'd4,
		OP_BORR = 4'd5,
		OP_BANR = 4'd6,
		OP_EQRI = 4'd7,
		OP_BANI = 4'd8,
		OP_ADDR = 4'd9,
		OP_ADDI = 4'd10,
		OP_EQRR = 4'd11,
		OP_GTRI = 4'd12,
		OP_EQIR = 4'd13,
		OP_SETR = 4'd14,
		OP_MULI = 4'd15
	} opcode_t;

	// write-back bypass for the register-file memory
	typedef struct packed {
		logic  valid;
		idx_t  idx;
		word_t data;
	} byp_t;

endpackage

@@ sv/froe_if.sv @@
// valid/ready channel interfaces for instructions and register results
interface froe_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [froe_pkg::OP_W-1:0]   command;
	logic [froe_pkg::IMM_W-1:0]  operand_a;
	logic [froe_pkg::IMM_W-1:0]  operand_b;
	logic [froe_pkg::IDX_W-1:0]  dest_index;

	modport source (output valid, command, operand_a, operand_b, dest_index, input ready);
	modport sink (input valid, command, operand_a, operand_b, dest_index, output ready);
endinterface

interface froe_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [froe_pkg::WORD_W-1:0]  reg_zero;
	logic signed [froe_pkg::WORD_W-1:0]  reg_one;
	logic signed [froe_pkg::WORD_W-1:0]  reg_two;
	logic signed [froe_pkg::WORD_W-1:0]  reg_three;

	modport source (output valid, reg_zero, reg_one, reg_two, reg_three, input ready);
	modport sink (input valid, reg_zero, reg_one, reg_two, reg_three, output ready);
endinterface

@@ sv/froe_ram.sv @@
// generic ram: one write port, two registered read ports
module froe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read-first: a same-edge write is not seen here
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

@@ sv/four_register_opcode_executor.sv @@
// Four-register opcode executor. Each cmd transaction is one instruction that runs on a
// four-entry 32-bit register file held in a small synchronous memory; each instruction
// gives exactly one res transaction carrying all four registers after it. A new
// instruction is taken every cycle while cmd is ready: the memory's read forms the first
// stage, the operand bypass, the ALU (one 32x32 multiplier) and the write-back the second,
// so a result passes the read registers, then the result register. The result register
// parts the two sides, so cmd stays ready while a result waits unless the second stage
// is also full. Reset clears per-entry valid bits, so there is no clearing pass.
module four_register_opcode_executor (
	input  logic clk,
	input  logic arst_n,
	froe_cmd_if.sink   cmd,
	froe_res_if.source res
);
	import froe_pkg::*;

	logic    take;
	logic    adv;
	logic    s1_v_q;
	opcode_t command_s1;
	imm_t    a_s1;
	imm_t    b_s1;
	idx_t    dest_s1;
	logic    vld_a_s1;
	logic    vld_b_s1;
	logic [NUM_REGS-1:0] vld_q;
	byp_t    byp_q;
	logic    out_v_q;
	word_t   file_q [NUM_REGS];

	word_t   ram_a;
	word_t   ram_b;
	word_t   ra;
	word_t   rb;
	word_t   ia;
	word_t   ib;
	word_t   mul_y;
	word_t   prod;
	word_t   result;

	assign take      = cmd.valid && cmd.ready;
	assign adv       = s1_v_q && (!out_v_q || res.ready);
	assign cmd.ready = !s1_v_q || !out_v_q || res.ready;

	froe_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_REGS)
	) u_rf (
		.clk     (clk),
		.we      (adv),
		.waddr   (dest_s1),
		.wdata   (result),
		.re      (take),
		.raddr_a (cmd.operand_a[IDX_W-1:0]),
		.raddr_b (cmd.operand_b[IDX_W-1:0]),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (take) begin
			s1_v_q <= 1'b1;
		end else if (adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			command_s1 <= opcode_t'(cmd.command);
			a_s1       <= cmd.operand_a;
			b_s1       <= cmd.operand_b;
			dest_s1    <= cmd.dest_index;
			vld_a_s1   <= vld_q[cmd.operand_a[IDX_W-1:0]];
			vld_b_s1   <= vld_q[cmd.operand_b[IDX_W-1:0]];
		end
	end

	// the write on the edge that read the memory is missed by the read, so forward it
	always_comb begin
		if (byp_q.valid && byp_q.idx == a_s1[IDX_W-1:0]) begin
			ra = byp_q.data;
		end else begin
			ra = vld_a_s1 ? ram_a : '0;
		end
		if (byp_q.valid && byp_q.idx == b_s1[IDX_W-1:0]) begin
			rb = byp_q.data;
		end else begin
			rb = vld_b_s1 ? ram_b : '0;
		end
	end

	assign ia    = {1'b0, a_s1};
	assign ib    = {1'b0, b_s1};
	assign mul_y = (command_s1 == OP_MULR) ? rb : ib;
	// only the low word of the product is kept
	assign prod  = ra * mul_y;

	always_comb begin
		unique case (command_s1)
			OP_GTIR: result = {{(WORD_W-1){1'b0}}, ($signed(ia) > $signed(rb))};
			OP_MULR: result = prod;
			OP_SETI: result = ia;
			OP_GTRR: result = {{(WORD_W-1){1'b0}}, ($signed(ra) > $signed(rb))};
			OP_BORI: result = ra | ib;
			OP_BORR: result = ra | rb;
			OP_BANR: result = ra & rb;
			OP_EQRI: result = {{(WORD_W-1){1'b0}}, (ra == ib)};
			OP_BANI: result = ra & ib;
			OP_ADDR: result = ra + rb;
			OP_ADDI: result = ra + ib;
			OP_EQRR: result = {{(WORD_W-1){1'b0}}, (ra == rb)};
			OP_GTRI: result = {{(WORD_W-1){1'b0}}, ($signed(ra) > $signed(ib))};
			OP_EQIR: result = {{(WORD_W-1){1'b0}}, (ia == rb)};
			OP_SETR: result = ra;
			OP_MULI: result = prod;
			default: result = '0;
		endcase
	end

	// result register doubles as the visible copy of the whole file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			byp_q   <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				file_q[i] <= '0;
			end
		end else begin
			if (adv) begin
				vld_q[dest_s1] <= 1'b1;
				byp_q          <= '{valid: 1'b1, idx: dest_s1, data: result};
				out_v_q        <= 1'b1;
				for (int i = 0; i < NUM_REGS; i++) begin
					if (dest_s1 == IDX_W'(i)) begin
						file_q[i] <= result;
					end
				end
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign res.valid     = out_v_q;
	assign res.reg_zero  = $signed(file_q[0]);
	assign res.reg_one   = $signed(file_q[1]);
	assign res.reg_two   = $signed(file_q[2]);
	assign res.reg_three = $signed(file_q[3]);

endmodule

@@ sv/froe_chk.sv @@
// port-level checks for the four-register opcode executor, bound to the top level
module froe_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] reg_zero,
	input logic [31:0] reg_one,
	input logic [31:0] reg_two,
	input logic [31:0] reg_three
);

	// a waiting result holds its registers
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({reg_zero, reg_one, reg_two, reg_three}))
		else $error("result changed while stalled");

	// a draining output never back-pressures the instruction side
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> cmd_ready)
		else $error("cmd not ready while res is being drained");

	// a result out of an empty output comes from an accepted transaction that passed the read and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("result without a matching instruction");

	// back-to-back results differ in one register at most
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) ##1 res_valid |->
			$countones({reg_zero != $past(reg_zero), reg_one != $past(reg_one),
				reg_two != $past(reg_two), reg_three != $past(reg_three)}) <= 1)
		else $error("more than one register changed by one instruction");

endmodule

bind four_register_opcode_executor froe_chk u_froe_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.reg_zero  (res.reg_zero),
	.reg_one   (res.reg_one),
	.reg_two   (res.reg_two),
	.reg_three (res.reg_three)
);

@@ verif/four_register_opcode_executor_tb.sv @@
// self-checking testbench for the four-register opcode executor
module four_register_opcode_executor_tb;
	import froe_pkg::*;

	typedef struct {
		opcode_t op;
		imm_t    a;
		imm_t    b;
		idx_t    dst;
	} instr_t;

	// index 0 holds register zero
	typedef logic [NUM_REGS-1:0][WORD_W-1:0] regs_t;

	localparam int RANDOM_INSTRS = 1300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	froe_cmd_if cmd_if ();
	froe_res_if res_if ();

	four_register_opcode_executor uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	always #5 clk = ~clk;

	// driven copies of the block inputs, known from time zero
	logic    drv_valid = 1'b0;
	opcode_t drv_op = OP_GTIR;
	imm_t    drv_a = '0;
	imm_t    drv_b = '0;
	idx_t    drv_dst = '0;
	logic    res_ready = 1'b0;

	assign cmd_if.valid      = drv_valid;
	assign cmd_if.command    = drv_op;
	assign cmd_if.operand_a  = drv_a;
	assign cmd_if.operand_b  = drv_b;
	assign cmd_if.dest_index = drv_dst;
	assign res_if.ready      = res_ready;

	instr_t pending_instrs[$];
	regs_t  expected_regs[$];
	imm_t   recent_imms[$];
	word_t  regfile_model [NUM_REGS] = '{default: '0};
	int     errors = 0;

	// executes one instruction on the model register file, returns all registers after it
	function automatic regs_t predict_regs(instr_t ins);
		word_t ra, rb, ia, ib, v;
		regs_t snap;
		ra = regfile_model[ins.a[IDX_W-1:0]];
		rb = regfile_model[ins.b[IDX_W-1:0]];
		ia = {1'b0, ins.a};
		ib = {1'b0, ins.b};
		case (ins.op)
			OP_GTIR: v = word_t'($signed(ia) > $signed(rb));
			OP_MULR: v = ra * rb;
			OP_SETI: v = ia;
			OP_GTRR: v = word_t'($signed(ra) > $signed(rb));
			OP_BORI: v = ra | ib;
			OP_BORR: v = ra | rb;
			OP_BANR: v = ra & rb;
			OP_EQRI: v = word_t'(ra == ib);
			OP_BANI: v = ra & ib;
			OP_ADDR: v = ra + rb;
			OP_ADDI: v = ra + ib;
			OP_EQRR: v = word_t'(ra == rb);
			OP_GTRI: v = word_t'($signed(ra) > $signed(ib));
			OP_EQIR: v = word_t'(ia == rb);
			OP_SETR: v = ra;
			default: v = ra * ib;
		endcase
		regfile_model[ins.dst] = v;
		for (int k = 0; k < NUM_REGS; k++)
			snap[k] = regfile_model[k];
		return snap;
	endfunction

	task automatic add_instr(opcode_t op, imm_t a, imm_t b, idx_t dst);
		instr_t ins;
		ins.op = op;
		ins.a = a;
		ins.b = b;
		ins.dst = dst;
		pending_instrs.insert(pending_instrs.size(), ins);
	endtask

	// operand field: small, extreme, fully random, or one of the recent SETI immediates and pooled random values
	function automatic imm_t pick_operand();
		case ($urandom_range(0, 6))
			0, 1: return imm_t'($urandom_range(0, 8));
			2: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return imm_t'(1);
					2: return '1;
					3: return {1'b1, {(IMM_W-1){1'b0}}};
					default: return {{(IMM_W-1){1'b1}}, 1'b0};
				endcase
			end
			3, 4: return imm_t'($urandom());
			default: begin
				if (recent_imms.size() == 0)
					return imm_t'($urandom());
				return recent_imms[$urandom_range(0, recent_imms.size() - 1)];
			end
		endcase
	endfunction

	// stimulus
	initial begin
		instr_t ins;
		imm_t   all_ones;
		all_ones = '1;

		// negative values via wrap, signed tests, overflow, index high bits ignored
		add_instr(OP_SETI, all_ones, imm_t'($urandom()), 2'd0);
		add_instr(OP_ADDR, 31'h7FFF_FFFC, 31'h4, 2'd1);
		add_instr(OP_GTRR, 31'h0, 31'h1, 2'd2);
		add_instr(OP_GTRI, 31'h1, 31'h0, 2'd3);
		add_instr(OP_GTIR, 31'h0, 31'h5, 2'd3);
		add_instr(OP_GTIR, all_ones, 31'h0, 2'd2);
		add_instr(OP_MULR, 31'h0, 31'h1, 2'd2);
		add_instr(OP_MULI, 31'h0, all_ones, 2'd3);
		add_instr(OP_ADDI, 31'h1, all_ones, 2'd2);
		add_instr(OP_EQRI, 31'h4, all_ones, 2'd3);
		add_instr(OP_EQIR, all_ones, 31'h7FFF_FFF8, 2'd2);
		add_instr(OP_EQRR, 31'h1, 31'h5, 2'd3);
		add_instr(OP_EQRR, 31'h0, 31'h1, 2'd3);
		add_instr(OP_BORI, 31'h1, 31'h0, 2'd2);
		add_instr(OP_BORR, 31'h0, 31'h1, 2'd2);
		add_instr(OP_BANR, 31'h0, 31'h1, 2'd3);
		add_instr(OP_BANI, 31'h1, all_ones, 2'd3);
		add_instr(OP_SETR, 31'h7FFF_FFF7, 31'h0, 2'd0);
		add_instr(OP_GTRI, 31'h0, all_ones, 2'd2);
		add_instr(OP_SETI, 31'h0, all_ones, 2'd1);
		add_instr(OP_EQRI, 31'h1, 31'h0, 2'd3);
		add_instr(OP_MULI, 31'h2, 31'h0, 2'd2);
		add_instr(OP_GTIR, 31'h0, 31'h1, 2'd0);
		add_instr(OP_EQIR, 31'h0, 31'h1, 2'd0);

		for (int n = 0; n < RANDOM_INSTRS; n++) begin
			ins.op = opcode_t'($urandom_range(0, 15));
			ins.a = pick_operand();
			ins.b = pick_operand();
			ins.dst = idx_t'($urandom_range(0, NUM_REGS - 1));
			if (ins.op == OP_SETI || $urandom_range(0, 7) == 0) begin
				recent_imms.insert(recent_imms.size(),
					ins.op == OP_SETI ? ins.a : imm_t'($urandom()));
				if (recent_imms.size() > 12)
					void'(recent_imms.pop_front());
			end
			pending_instrs.insert(pending_instrs.size(), ins);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_instrs.size() != 0 || drv_valid)
			@(posedge clk);
		while (expected_regs.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("four_register_opcode_executor regression: pass");
		else
			$display("four_register_opcode_executor regression: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("four_register_opcode_executor regression: fail");
		$finish;
	end

	// driver: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	instr_t next_instr;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (!drv_valid || cmd_if.ready) begin
			if (gap_left != 0) begin
				drv_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_instrs.size() != 0) begin
				next_instr = pending_instrs.pop_front();
				drv_op <= next_instr.op;
				drv_a <= next_instr.a;
				drv_b <= next_instr.b;
				drv_dst <= next_instr.dst;
				drv_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
						: $urandom_range(1, 16);
					gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
						: $urandom_range(0, 4);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// predictor: one expectation per accepted instruction
	instr_t accepted_instr;

	always @(posedge clk) begin
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			accepted_instr.op = opcode_t'(cmd_if.command);
			accepted_instr.a = cmd_if.operand_a;
			accepted_instr.b = cmd_if.operand_b;
			accepted_instr.dst = cmd_if.dest_index;
			expected_regs.insert(expected_regs.size(), predict_regs(accepted_instr));
		end
	end

	// monitor: result-side stall pattern steps through four modes as the cycle counter runs
	int    cycle_cnt = 0;
	regs_t want_regs;
	regs_t got_regs;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			case ((cycle_cnt >> 8) % 4)
				0: res_ready <= 1'b1;
				1: res_ready <= (cycle_cnt % 5) != 0;
				2: res_ready <= 1'($urandom_range(0, 1));
				default: res_ready <= (cycle_cnt % 16) < 11;
			endcase
			if (res_if.valid && res_if.ready) begin
				got_regs = {res_if.reg_three, res_if.reg_two, res_if.reg_one, res_if.reg_zero};
				if (expected_regs.size() == 0) begin
					$display("%0t: unexpected result transaction, got %h", $time, got_regs);
					errors++;
				end else begin
					want_regs = expected_regs.pop_front();
					for (int k = 0; k < NUM_REGS; k++) begin
						if (got_regs[k] !== want_regs[k]) begin
							$display("%0t: register %0d expected %h actual %h",
								$time, k, want_regs[k], got_regs[k]);
							errors++;
						end
					end
				end
			end
		end
	end

endmodule
